/* hdl/msr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the motor speed regulator.
// No dependencies; every module of the block imports this package.
package msr_pkg;

   localparam int STAMP_W   = 48;
   localparam int SPEED_W   = 26;
   localparam int DUTY_W    = 7;
   localparam int COLOR_W   = 24;
   localparam int SHORT_W   = 16;
   localparam int LONG_W    = 32;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 5;
   localparam int REG_IDX_W = 3;
   localparam int GAIN_W    = SHORT_W;
   localparam int ERR_W     = SPEED_W + 1;
   localparam int PROD_W    = GAIN_W + ERR_W;
   localparam int WIN_W     = SPEED_W + 2;
   localparam int REM_W     = SPEED_W + 1;

   // sixty seconds in microseconds
   localparam logic [SPEED_W-1:0] RPM_NUM = 26'd60000000;

   localparam logic [COLOR_W-1:0] COLOR_RED    = 24'hFF0000;
   localparam logic [COLOR_W-1:0] COLOR_YELLOW = 24'hFFFF00;
   localparam logic [COLOR_W-1:0] COLOR_GREEN  = 24'h00FF00;
   localparam logic [COLOR_W-1:0] COLOR_CYAN   = 24'h00FFFF;
   localparam logic [COLOR_W-1:0] COLOR_BLUE   = 24'h0000FF;
   localparam logic [COLOR_W-1:0] COLOR_OFF    = 24'hFF00A0;

   localparam logic [DUTY_W-1:0] DUTY_50  = 7'd50;
   localparam logic [DUTY_W-1:0] DUTY_80  = 7'd80;
   localparam logic [DUTY_W-1:0] DUTY_85  = 7'd85;
   localparam logic [DUTY_W-1:0] DUTY_90  = 7'd90;
   localparam logic [DUTY_W-1:0] DUTY_95  = 7'd95;
   localparam logic [DUTY_W-1:0] DUTY_100 = 7'd100;

   localparam logic [SHORT_W-1:0] TARGET_RST  = 16'd1736;
   localparam logic [SHORT_W-1:0] GAIN_RST    = 16'd655;
   localparam logic [SHORT_W-1:0] WINDOW_RST  = 16'd50;
   localparam logic [LONG_W-1:0]  TIMEOUT_RST = 32'd3000000;
   localparam logic [LONG_W-1:0]  HOLD_RST    = 32'd3000000;

   localparam logic [REG_IDX_W-1:0] REG_TARGET  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GAIN    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_HOLD    = 3'd4;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic [SHORT_W-1:0] target_speed;
      logic [SHORT_W-1:0] loop_gain;
      logic [SHORT_W-1:0] speed_window;
      logic [LONG_W-1:0]  edge_timeout;
      logic [LONG_W-1:0]  startup_hold;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SPLIT,
      ST_DIV,
      ST_MUL,
      ST_CLAMP,
      ST_STORE
   } state_type;

endpackage

/* hdl/msr_csr.sv */
`timescale 1ns / 1ps
// Configuration registers behind an APB-style slave port.
// Depends on msr_pkg for the register indexes and the cfg_type bundle.
module msr_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [msr_pkg::ADDR_W-1:0]  paddr,
   input  logic [msr_pkg::DATA_W-1:0]  pwdata,
   output logic [msr_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output msr_pkg::cfg_type            cfg
);
   import msr_pkg::*;

   cfg_type               cfg_ff;
   logic [REG_IDX_W-1:0]  idx;
   logic                  wr_en;

   assign pready = 1'b1;
   assign idx    = paddr[ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_speed <= TARGET_RST;
         cfg_ff.loop_gain    <= GAIN_RST;
         cfg_ff.speed_window <= WINDOW_RST;
         cfg_ff.edge_timeout <= TIMEOUT_RST;
         cfg_ff.startup_hold <= HOLD_RST;
      end else if (wr_en) begin
         case (idx)
            REG_TARGET:  cfg_ff.target_speed <= pwdata[SHORT_W-1:0];
            REG_GAIN:    cfg_ff.loop_gain    <= pwdata[SHORT_W-1:0];
            REG_WINDOW:  cfg_ff.speed_window <= pwdata[SHORT_W-1:0];
            REG_TIMEOUT: cfg_ff.edge_timeout <= pwdata[LONG_W-1:0];
            REG_HOLD:    cfg_ff.startup_hold <= pwdata[LONG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_TARGET:  prdata = DATA_W'(cfg_ff.target_speed);
         REG_GAIN:    prdata = DATA_W'(cfg_ff.loop_gain);
         REG_WINDOW:  prdata = DATA_W'(cfg_ff.speed_window);
         REG_TIMEOUT: prdata = DATA_W'(cfg_ff.edge_timeout);
         REG_HOLD:    prdata = DATA_W'(cfg_ff.startup_hold);
         default:     prdata = '0;
      endcase
   end

endmodule

/* hdl/msr_div.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider: 60000000 / divisor, one quotient bit per cycle.
// Depends on msr_pkg for the numerator and the quotient width.
module msr_div #(
   parameter int TIME_BITS = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [TIME_BITS-1:0]         divisor,
   output logic                         done,
   output logic [msr_pkg::SPEED_W-1:0]  quot
);
   import msr_pkg::*;

   localparam int CNT_W = $clog2(SPEED_W);

   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [TIME_BITS-1:0] dsr_ff;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [SPEED_W-1:0]   quot_ff, quot_in;
   logic [REM_W-1:0]     trial;
   logic                 big;
   logic                 fits;

   // remainder never reaches 2^26, so a divisor with any high bit set never fits
   assign trial = {rem_ff[REM_W-2:0], RPM_NUM[cnt_ff]};
   assign big   = |dsr_ff[TIME_BITS-1:REM_W];
   assign fits  = !big && (trial >= dsr_ff[REM_W-1:0]);
   assign done  = busy_ff && (cnt_ff == '0);
   assign quot  = quot_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SPEED_W - 1);
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? (trial - dsr_ff[REM_W-1:0]) : trial;
         quot_in = {quot_ff[SPEED_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

endmodule

/* hdl/msr_mul.sv */
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: unsigned gain times signed speed error.
// Depends on msr_pkg for operand and product widths.
module msr_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [msr_pkg::GAIN_W-1:0]         gain,
   input  logic signed [msr_pkg::ERR_W-1:0]   err,
   output logic                               done,
   output logic signed [msr_pkg::PROD_W-1:0]  prod
);
   import msr_pkg::*;

   localparam int CNT_W = $clog2(GAIN_W);

   logic                     busy_ff, busy_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [GAIN_W-1:0]        mplr_ff, mplr_in;
   logic signed [PROD_W-1:0] mcand_ff, mcand_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   assign done = busy_ff && (cnt_ff == '0);
   assign prod = prod_ff;

   // gain bits enter LSB first; the error shifts up one place each cycle
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      mplr_in  = mplr_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(GAIN_W - 1);
         mplr_in  = gain;
         mcand_in = PROD_W'(err);
         prod_in  = '0;
      end else if (busy_ff) begin
         if (mplr_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mplr_in  = mplr_ff >> 1;
         mcand_in = mcand_ff <<< 1;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mplr_ff  <= mplr_in;
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

endmodule

/* hdl/motor_speed_regulator_unit.sv */
`timescale 1ns / 1ps
// Motor speed regulator top level: sequencer, state and result register.
// Depends on msr_pkg, msr_csr, msr_div and msr_mul.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_op, req_stamp
//   rsp      out        rsp_valid / rsp_stall   motor_on, duty, in_window, speed, led
//   csr      in         psel/penable/pready     paddr, pwdata, prdata
//
// An edge item runs through the 26-step serial divider unless its interval is
// zero; a tick runs through the 16-step serial multiplier when enabled and skips
// it when disabled. One item is in work at a time.
// Synchronous reset restores the sequencer and regulator state; no clearing pass.
// A stalled result holds in the output register; the next item is taken
// while it waits, and its result holds until the register frees up.
module motor_speed_regulator_unit #(
   parameter int TIME_BITS      = 48,
   parameter int DUTY_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [msr_pkg::STAMP_W-1:0]  req_stamp,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_motor_on,
   output logic [msr_pkg::DUTY_W-1:0]   rsp_duty_percent,
   output logic                         rsp_in_window,
   output logic [msr_pkg::SPEED_W-1:0]  rsp_speed_now,
   output logic [msr_pkg::COLOR_W-1:0]  rsp_led_rgb,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [msr_pkg::ADDR_W-1:0]   paddr,
   input  logic [msr_pkg::DATA_W-1:0]   pwdata,
   output logic [msr_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);
   import msr_pkg::*;

   localparam int AW    = DUTY_W + DUTY_FRAC_BITS;
   localparam int LSH   = (DUTY_FRAC_BITS >= 16) ? DUTY_FRAC_BITS - 16 : 0;
   localparam int RSH   = (DUTY_FRAC_BITS >= 16) ? 0 : 16 - DUTY_FRAC_BITS;
   localparam int SUM_W = PROD_W + LSH + 2;

   localparam logic [AW-1:0] ACC_RST = {DUTY_50,  {DUTY_FRAC_BITS{1'b0}}};
   localparam logic [AW-1:0] PCT80   = {DUTY_80,  {DUTY_FRAC_BITS{1'b0}}};
   localparam logic [AW-1:0] PCT85   = {DUTY_85,  {DUTY_FRAC_BITS{1'b0}}};
   localparam logic [AW-1:0] PCT90   = {DUTY_90,  {DUTY_FRAC_BITS{1'b0}}};
   localparam logic [AW-1:0] PCT95   = {DUTY_95,  {DUTY_FRAC_BITS{1'b0}}};
   localparam logic [AW-1:0] PCT100  = {DUTY_100, {DUTY_FRAC_BITS{1'b0}}};

   cfg_type cfg;

   state_type state_ff, state_in;

   logic                  op_ff;
   logic [TIME_BITS-1:0]  now_ff;
   logic [TIME_BITS-1:0]  diff_ff;
   logic                  late_ff;
   logic [AW-1:0]         sum_ff;

   logic [TIME_BITS-1:0]  last_edge_ff, last_edge_in;
   logic [SPEED_W-1:0]    speed_ff, speed_in;
   logic [AW-1:0]         acc_ff, acc_in;
   logic                  enabled_ff, enabled_in;
   logic                  target_ff, target_in;
   logic [COLOR_W-1:0]    color_ff, color_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_motor_on_ff;
   logic [DUTY_W-1:0]     rsp_duty_ff;
   logic                  rsp_in_window_ff;
   logic [SPEED_W-1:0]    rsp_speed_ff;
   logic [COLOR_W-1:0]    rsp_led_ff;

   logic                  req_take;
   logic                  diff_zero;
   logic                  div_start, div_done;
   logic [SPEED_W-1:0]    div_quot;
   logic                  mul_start, mul_done;
   logic signed [PROD_W-1:0] mul_prod;
   logic signed [ERR_W-1:0]  err;
   logic signed [SUM_W-1:0]  step_scaled;
   logic signed [SUM_W-1:0]  sum_raw;
   logic [AW-1:0]         sum_clamp;
   logic signed [WIN_W-1:0]  win_lo, win_hi, win_sp;
   logic                  win_hit;
   logic [COLOR_W-1:0]    band;
   logic                  store_go;

   msr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   msr_div #(.TIME_BITS(TIME_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (diff_ff),
      .done    (div_done),
      .quot    (div_quot)
   );

   msr_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .gain  (cfg.loop_gain),
      .err   (err),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign req_take  = req_valid && !req_stall;
   assign diff_zero = (diff_ff == '0);
   assign err = signed'(ERR_W'(cfg.target_speed)) - signed'(ERR_W'(speed_ff));

   // scale Q.16 step to the accumulator's fraction; arithmetic shift floors
   assign step_scaled = (SUM_W'(mul_prod) <<< LSH) >>> RSH;
   assign sum_raw     = step_scaled + signed'(SUM_W'(acc_ff));

   always_comb begin
      if (sum_raw < 0) begin
         sum_clamp = '0;
      end else if (sum_raw > signed'(SUM_W'(PCT100))) begin
         sum_clamp = PCT100;
      end else begin
         sum_clamp = AW'(sum_raw);
      end
   end

   assign win_sp  = signed'(WIN_W'(speed_ff));
   assign win_lo  = signed'(WIN_W'(cfg.target_speed)) - signed'(WIN_W'(cfg.speed_window));
   assign win_hi  = signed'(WIN_W'(cfg.target_speed)) + signed'(WIN_W'(cfg.speed_window));
   assign win_hit = (win_sp > win_lo) && (win_sp < win_hi);

   always_comb begin
      if (sum_ff < PCT80) begin
         band = COLOR_RED;
      end else if (sum_ff < PCT85) begin
         band = COLOR_YELLOW;
      end else if (sum_ff < PCT90) begin
         band = COLOR_GREEN;
      end else if (sum_ff < PCT95) begin
         band = COLOR_CYAN;
      end else begin
         band = COLOR_BLUE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: state_in = ST_SPLIT;
         ST_SPLIT: begin
            if (op_ff == OP_EDGE) begin
               state_in = diff_zero ? ST_STORE : ST_DIV;
            end else begin
               state_in = enabled_ff ? ST_MUL : ST_STORE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: state_in = ST_STORE;
         ST_STORE: begin
            if (store_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      mul_start = 1'b0;
      store_go  = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_SPLIT: begin
            div_start = (op_ff == OP_EDGE) && !diff_zero;
            mul_start = (op_ff == OP_TICK) && enabled_ff;
         end
         ST_STORE: store_go = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // state after this item
   always_comb begin
      last_edge_in = last_edge_ff;
      speed_in     = speed_ff;
      acc_in       = acc_ff;
      enabled_in   = enabled_ff;
      target_in    = target_ff;
      color_in     = color_ff;
      if (op_ff == OP_EDGE) begin
         speed_in     = diff_zero ? '0 : div_quot;
         last_edge_in = now_ff;
      end else begin
         if (enabled_ff) begin
            acc_in    = sum_ff;
            target_in = win_hit;
            color_in  = band;
         end else begin
            color_in  = COLOR_OFF;
         end
         if (late_ff) begin
            enabled_in = 1'b0;
            target_in  = 1'b0;
            acc_in     = ACC_RST;
         end else begin
            enabled_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (store_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_edge_ff <= '0;
         speed_ff     <= '0;
         acc_ff       <= ACC_RST;
         enabled_ff   <= 1'b0;
         target_ff    <= 1'b0;
         color_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (store_go) begin
            last_edge_ff <= last_edge_in;
            speed_ff     <= speed_in;
            acc_ff       <= acc_in;
            enabled_ff   <= enabled_in;
            target_ff    <= target_in;
            color_ff     <= color_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_op;
         now_ff <= TIME_BITS'(req_stamp);
      end
      if (state_ff == ST_DIFF) begin
         diff_ff <= now_ff - last_edge_ff;
      end
      if (state_ff == ST_SPLIT) begin
         late_ff <= (diff_ff > TIME_BITS'(cfg.edge_timeout)) ||
                    (now_ff < TIME_BITS'(cfg.startup_hold));
      end
      if (state_ff == ST_CLAMP) begin
         sum_ff <= sum_clamp;
      end
      if (store_go) begin
         rsp_motor_on_ff  <= enabled_in;
         rsp_duty_ff      <= enabled_in ? acc_in[AW-1 -: DUTY_W] : '0;
         rsp_in_window_ff <= target_in;
         rsp_speed_ff     <= speed_in;
         rsp_led_ff       <= color_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motor_on     = rsp_motor_on_ff;
   assign rsp_duty_percent = rsp_duty_ff;
   assign rsp_in_window    = rsp_in_window_ff;
   assign rsp_speed_now    = rsp_speed_ff;
   assign rsp_led_rgb      = rsp_led_ff;

endmodule

/* hdl/msr_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the motor speed regulator, bound to the top level.
// Depends on msr_pkg for field widths.
module msr_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_motor_on,
   input logic [msr_pkg::DUTY_W-1:0]   rsp_duty_percent,
   input logic                         rsp_in_window,
   input logic [msr_pkg::SPEED_W-1:0]  rsp_speed_now,
   input logic [msr_pkg::COLOR_W-1:0]  rsp_led_rgb
);
   import msr_pkg::*;

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_led_rgb) && $stable(rsp_speed_now) &&
                                 $stable(rsp_duty_percent))
      else $error("stalled result changed");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken before the first finished");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_percent <= DUTY_100)
      else $error("duty above full scale");

   a_off_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_motor_on |-> rsp_duty_percent == '0 && !rsp_in_window)
      else $error("disabled motor shows drive or at-target");

endmodule

bind motor_speed_regulator_unit msr_chk u_msr_chk (.*);
